FILE: hdl/lzw_pkg.sv
package lzw_pkg;

  localparam int MAX_CODE_BITS_DEF = 12;
  localparam int FIRST_CODE        = 256;
  localparam int OUT_W             = 12;
  localparam int CFG_W             = 4;
  localparam int MIN_BITS          = 9;
  localparam logic [CFG_W-1:0] CODE_BITS_RST = 4'd12;

  typedef struct packed {
    logic [OUT_W-1:0] code;
    logic             last;
  } res_t;

  typedef struct packed {
    logic v0;
    res_t d0;
    logic v1;
    res_t d1;
  } push_t;

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_LOOK  = 3'b100
  } state_t;

endpackage

FILE: hdl/lzw_if.sv
interface lzw_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;
  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface lzw_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] out_code;
  logic        out_last;
  modport source (output valid, output out_code, output out_last, input ready);
  modport sink   (input valid, input out_code, input out_last, output ready);
endinterface

interface lzw_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/lzw_ram.sv
module lzw_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/lzw_outq.sv
module lzw_outq (
  input  logic          clk,
  input  logic          rst_n,
  input  lzw_pkg::push_t push,
  output logic          room,
  lzw_out_if.source     out_ch
);
  import lzw_pkg::*;

  res_t       q_r [4];
  logic [1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       pop;

  assign pop             = out_ch.valid && out_ch.ready;
  assign out_ch.valid    = (cnt_r != 3'd0);
  assign out_ch.out_code = q_r[rp_r].code;
  assign out_ch.out_last = q_r[rp_r].last;
  assign room            = (cnt_r <= 3'd2);

  always_comb begin
    wp_nxt  = wp_r + 2'(push.v0) + 2'(push.v1);
    rp_nxt  = rp_r + 2'(pop);
    cnt_nxt = cnt_r + 3'(push.v0) + 3'(push.v1) - 3'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.v0) begin
      q_r[wp_r] <= push.d0;
    end
    if (push.v1) begin
      q_r[wp_r + 2'd1] <= push.d1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 3'd4)
    else $error("output queue overflow");
  a_push_order: assert property (@(posedge clk) disable iff (!rst_n) push.v1 |-> push.v0)
    else $error("second push without first");
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push.v0 && push.v1) |-> (cnt_r <= 3'd2 || (cnt_r == 3'd3 && pop)))
    else $error("double push without room");
`endif

endmodule

FILE: hdl/lzw_compressor.sv
// channel | dir | payload            | transfer
// in_ch   | in  | in_byte, in_last   | valid && ready
// out_ch  | out | out_code, out_last | valid && ready
// cfg_ch  | in  | data (code_bits)   | valid && ready
// A byte with no held prefix ends in S_IDLE; else S_LOOK probes to a hit or a free entry.
// The hash table is a 2^(MAX_CODE_BITS+1) entry RAM, at most half full, so probes are short.
// After reset a clearing pass over all 2^(MAX_CODE_BITS+1) entries holds in_ch.ready low.
// A 4-entry output queue lets input continue while results wait; ready needs two free slots.
module lzw_compressor #(
  parameter int MAX_CODE_BITS = lzw_pkg::MAX_CODE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  lzw_in_if.sink    in_ch,
  lzw_out_if.source out_ch,
  lzw_cfg_if.sink   cfg_ch
);
  import lzw_pkg::*;

  localparam int TB    = MAX_CODE_BITS + 1;
  localparam int DEPTH = 1 << TB;
  localparam int CW    = MAX_CODE_BITS;
  localparam int EW    = 1 + CW + 8 + CW;

  typedef struct packed {
    logic          valid;
    logic [CW-1:0] prefix;
    logic [7:0]    byte_v;
    logic [CW-1:0] code;
  } ent_t;

  state_t          state_r, state_nxt;
  logic [TB-1:0]   clr_r, clr_nxt;
  logic [TB-1:0]   probe_r, probe_nxt;
  logic [CW-1:0]   prefix_r, prefix_nxt;
  logic            pvalid_r, pvalid_nxt;
  logic [CW:0]     nfc_r, nfc_nxt;
  logic [CFG_W-1:0] cb_r;
  logic [7:0]      byte_r, byte_nxt;
  logic            last_r, last_nxt;

  logic            we;
  logic [TB-1:0]   waddr, raddr;
  ent_t            wdata, rent;
  logic [EW-1:0]   rdata;
  push_t           push;
  logic            room, acc;
  logic [4:0]      eff;
  logic [CW:0]     limit;
  logic [TB-1:0]   hash;

  lzw_ram #(.W(EW), .D(DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  lzw_outq u_outq (.clk(clk), .rst_n(rst_n), .push(push), .room(room), .out_ch(out_ch));

  assign rent         = ent_t'(rdata);
  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = (state_r == S_IDLE) && room;
  assign acc          = in_ch.valid && in_ch.ready;

  always_comb begin
    if ({1'b0, cb_r} < 5'(MIN_BITS)) begin
      eff = 5'(MIN_BITS);
    end else if ({1'b0, cb_r} > 5'(MAX_CODE_BITS)) begin
      eff = 5'(MAX_CODE_BITS);
    end else begin
      eff = {1'b0, cb_r};
    end
    limit = (CW+1)'(1) << eff;
    hash  = TB'({prefix_r, 1'b0}) ^ TB'({in_ch.in_byte, {(TB-8){1'b0}}});
  end

  always_comb begin
    state_nxt  = state_r;
    clr_nxt    = clr_r;
    probe_nxt  = probe_r;
    prefix_nxt = prefix_r;
    pvalid_nxt = pvalid_r;
    nfc_nxt    = nfc_r;
    byte_nxt   = byte_r;
    last_nxt   = last_r;
    we         = 1'b0;
    waddr      = clr_r;
    wdata      = '0;
    raddr      = hash;
    push       = '0;
    case (state_r)
      S_CLEAR: begin
        we      = 1'b1;
        clr_nxt = clr_r + TB'(1);
        if (clr_r == {TB{1'b1}}) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (acc) begin
          byte_nxt = in_ch.in_byte;
          last_nxt = in_ch.in_last;
          if (!pvalid_r) begin
            if (in_ch.in_last) begin
              push.v0    = 1'b1;
              push.d0    = '{code: OUT_W'(in_ch.in_byte), last: 1'b1};
              prefix_nxt = '0;
            end else begin
              prefix_nxt = CW'(in_ch.in_byte);
              pvalid_nxt = 1'b1;
            end
          end else begin
            probe_nxt = hash;
            state_nxt = S_LOOK;
          end
        end
      end
      S_LOOK: begin
        if (rent.valid && rent.prefix == prefix_r && rent.byte_v == byte_r) begin
          state_nxt = S_IDLE;
          if (last_r) begin
            push.v0    = 1'b1;
            push.d0    = '{code: OUT_W'(rent.code), last: 1'b1};
            prefix_nxt = '0;
            pvalid_nxt = 1'b0;
          end else begin
            prefix_nxt = rent.code;
          end
        end else if (rent.valid) begin
          probe_nxt = probe_r + TB'(1);
          raddr     = probe_r + TB'(1);
        end else begin
          state_nxt = S_IDLE;
          push.v0   = 1'b1;
          push.d0   = '{code: OUT_W'(prefix_r), last: 1'b0};
          if (nfc_r < limit) begin
            we      = 1'b1;
            waddr   = probe_r;
            wdata   = '{valid: 1'b1, prefix: prefix_r, byte_v: byte_r, code: CW'(nfc_r)};
            nfc_nxt = nfc_r + (CW+1)'(1);
          end
          if (last_r) begin
            push.v1    = 1'b1;
            push.d1    = '{code: OUT_W'(byte_r), last: 1'b1};
            prefix_nxt = '0;
            pvalid_nxt = 1'b0;
          end else begin
            prefix_nxt = CW'(byte_r);
          end
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    probe_r <= probe_nxt;
    byte_r  <= byte_nxt;
    last_r  <= last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      clr_r    <= '0;
      prefix_r <= '0;
      pvalid_r <= 1'b0;
      nfc_r    <= (CW+1)'(FIRST_CODE);
      cb_r     <= CODE_BITS_RST;
    end else begin
      state_r  <= state_nxt;
      clr_r    <= clr_nxt;
      prefix_r <= prefix_nxt;
      pvalid_r <= pvalid_nxt;
      nfc_r    <= nfc_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        cb_r <= cfg_ch.data;
      end
    end
  end

`ifndef ASSERT_OFF
  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLEAR |-> !in_ch.ready)
    else $error("input taken during clear");
  a_nfc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    nfc_r <= ((CW+1)'(1) << MAX_CODE_BITS))
    else $error("next code past table range");
  a_look_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_LOOK |-> pvalid_r)
    else $error("lookup without prefix");
  a_nfc_step: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_LOOK |=> $stable(nfc_r))
    else $error("next code moved outside lookup");
`endif

endmodule

FILE: verif/tb_top.sv
module tb_top;
  import lzw_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #6 clk = ~clk;

  lzw_in_if  in_ch();
  lzw_out_if out_ch();
  lzw_cfg_if cfg_ch();

  lzw_compressor u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  localparam int DEPTH = (1 << MAX_CODE_BITS_DEF) - FIRST_CODE;

  logic [11:0] dict_pfx [DEPTH];
  logic [7:0]  dict_byt [DEPTH];
  int unsigned nxt_code;
  logic [11:0] cur_pfx;
  bit          pfx_held;
  logic [3:0]  width_reg;

  res_t codes_q[$];
  int   errors;
  int   cycles;
  bit   hold_off;
  int   hold_cnt;
  bit   long_stall_req;

  function automatic int unsigned width_limit();
    int unsigned b;
    b = 32'(width_reg);
    if (b < MIN_BITS) b = MIN_BITS;
    if (b > MAX_CODE_BITS_DEF) b = MAX_CODE_BITS_DEF;
    return 1 << b;
  endfunction

  function automatic void expect_code(input logic [11:0] code, input logic l);
    res_t r;
    r.code = code;
    r.last = l;
    codes_q.insert(codes_q.size(), r);
  endfunction

  task automatic predict_codes(input logic [7:0] b, input logic l);
    int unsigned hit;
    hit = 0;
    if (!pfx_held) begin
      cur_pfx = {4'd0, b};
      pfx_held = 1'b1;
    end else begin
      for (int unsigned c = FIRST_CODE; c < nxt_code; c++)
        if (hit == 0 && dict_pfx[c-FIRST_CODE] == cur_pfx && dict_byt[c-FIRST_CODE] == b)
          hit = c;
      if (hit != 0) begin
        cur_pfx = hit[11:0];
      end else begin
        expect_code(cur_pfx, 1'b0);
        if (nxt_code < width_limit()) begin
          dict_pfx[nxt_code-FIRST_CODE] = cur_pfx;
          dict_byt[nxt_code-FIRST_CODE] = b;
          nxt_code++;
        end
        cur_pfx = {4'd0, b};
      end
    end
    if (l) begin
      expect_code(cur_pfx, 1'b1);
      pfx_held = 1'b0;
      cur_pfx = '0;
    end
  endtask

  function automatic int rand_gap();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // result checker and receiver stalls
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (codes_q.size() == 0) begin
        $display("%0t unexpected code %0d last %0b", $time, out_ch.out_code, out_ch.out_last);
        errors++;
      end else begin
        res_t e;
        e = codes_q.pop_front();
        if (e.code !== out_ch.out_code) begin
          $display("%0t code exp %0d got %0d", $time, e.code, out_ch.out_code);
          errors++;
        end
        if (e.last !== out_ch.out_last) begin
          $display("%0t last exp %0b got %0b", $time, e.last, out_ch.out_last);
          errors++;
        end
      end
    end
    if (long_stall_req) begin
      long_stall_req <= 1'b0;
      hold_cnt <= 400;
      out_ch.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ch.ready <= 1'b0;
    end else if (hold_off) begin
      out_ch.ready <= 1'b1;
    end else begin
      int g;
      g = rand_gap();
      if (g > 0) begin
        hold_cnt <= g - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic l, input bit gaps);
    int g;
    g = gaps ? rand_gap() : 0;
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.in_byte <= b;
    in_ch.in_last <= l;
    do @(posedge clk); while (!in_ch.ready);
    predict_codes(b, l);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (codes_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_width(input logic [3:0] w);
    drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= w;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    width_reg = w;
  endtask

  task automatic test_directed();
    send_byte(8'h00, 1'b1, 0);
    send_byte(8'hFF, 1'b1, 0);
    send_byte(8'h41, 1'b0, 0);
    send_byte(8'h42, 1'b1, 0);
    send_byte(8'h41, 1'b0, 0);
    send_byte(8'h42, 1'b1, 0);
    send_byte(8'h41, 1'b0, 0);
    send_byte(8'h42, 1'b0, 0);
    send_byte(8'h41, 1'b0, 0);
    send_byte(8'h42, 1'b0, 0);
    send_byte(8'h41, 1'b0, 0);
    send_byte(8'hFF, 1'b1, 0);
    for (int i = 0; i < 8; i++) send_byte(8'h00, i == 7, 0);
    drain();
  endtask

  task automatic test_random(input int n, input int alpha);
    for (int i = 0; i < n; i++) begin
      logic [7:0] b;
      if ($urandom_range(0, 9) == 0) b = 8'($urandom_range(0, 255));
      else b = 8'($urandom_range(0, alpha - 1)) ^ 8'hA5;
      send_byte(b, $urandom_range(0, 15) == 0, 1);
    end
  endtask

  task automatic test_backpressure();
    @(posedge clk);
    long_stall_req <= 1'b1;
    for (int i = 0; i < 60; i++) send_byte(8'($urandom_range(0, 255)), i == 59, 0);
    drain();
  endtask

  task automatic test_widths();
    write_width(4'd9);
    test_random(300, 4);
    write_width(4'd0);
    test_random(150, 256);
    write_width(4'd15);
    test_random(200, 8);
    write_width(4'd10);
    test_random(150, 3);
    write_width(4'd12);
    test_random(200, 16);
    write_width(4'd11);
    test_random(150, 2);
    drain();
  endtask

  initial begin
    errors = 0; cycles = 0; hold_off = 0; hold_cnt = 0; long_stall_req = 0;
    in_ch.valid = 1'b0; in_ch.in_byte = '0; in_ch.in_last = 1'b0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0; cfg_ch.data = '0;
    nxt_code = FIRST_CODE; cur_pfx = '0; pfx_held = 0; width_reg = CODE_BITS_RST;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_backpressure();
    test_widths();
    drain();
    if (errors == 0 && codes_q.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

FILE: lzw_compressor.f
hdl/lzw_pkg.sv
hdl/lzw_if.sv
hdl/lzw_ram.sv
hdl/lzw_outq.sv
hdl/lzw_compressor.sv
verif/tb_top.sv
